// File: rtl/core/att_pkg.sv
package att_pkg;

	localparam int ADDRESS_BITS = 48;
	localparam int SIZE_BITS    = 32;
	localparam int OWNER_BITS   = 4;
	localparam int OWNERS       = 1 << OWNER_BITS;
	localparam int COUNT_BITS   = 11;

	// One stored slot: valid, owner, size and address, packed from the top down.
	localparam int WORD_BITS = 1 + OWNER_BITS + SIZE_BITS + ADDRESS_BITS;

	typedef enum logic [1:0] {
		OP_EVENT = 2'd0,
		OP_COUNT = 2'd1,
		OP_BEGIN = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_ALLOC     = 4'd0,
		ST_FREED     = 4'd1,
		ST_REALLOC   = 4'd2,
		ST_FAILED    = 4'd3,
		ST_OOM       = 4'd4,
		ST_UNTRACKED = 4'd5,
		ST_DUP       = 4'd6,
		ST_MISMATCH  = 4'd7,
		ST_COUNT     = 4'd8,
		ST_CLEARED   = 4'd9
	} status_t;

	typedef enum logic [1:0] {
		EV_ALLOC,
		EV_FREE,
		EV_REALLOC
	} ev_kind_t;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_SCAN,
		FSM_DRAIN,
		FSM_DECIDE
	} fsm_t;

	typedef struct packed {
		logic [1:0]              opcode;
		logic [OWNER_BITS-1:0]   owner_id;
		logic                    query_all;
		logic [ADDRESS_BITS-1:0] old_address;
		logic [SIZE_BITS-1:0]    request_size;
		logic [ADDRESS_BITS-1:0] new_address;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [COUNT_BITS-1:0]  live_count;
		logic                   out_of_memory;
	} rsp_t;

endpackage

// File: rtl/core/allocation_tracking_table.sv
// Channel   | Signals                 | Handshake
// ----------+-------------------------+-----------------------------------------
// request   | start, busy, request    | taken at a rising edge with start & !busy
// result    | done, result            | one-cycle strobe, no back pressure
//
// Count queries, begin, unused opcodes and events that fail early (null
// returned address, or an allocate while out of memory) answer in the cycle
// after the request. Every other allocator event scans the whole slot memory
// through its single read port, one slot per cycle, and answers after the
// scan, a drain state and a decide state. After reset and after every begin
// a clearing pass writes each slot invalid, one per cycle; busy is high
// throughout. The receiver cannot stall, so results never wait.
module allocation_tracking_table #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  att_pkg::req_t   request,
	output logic            done,
	output att_pkg::rsp_t   result
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int AB = att_pkg::ADDRESS_BITS;
	localparam int SB = att_pkg::SIZE_BITS;
	localparam int OB = att_pkg::OWNER_BITS;
	localparam int WB = att_pkg::WORD_BITS;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	att_pkg::fsm_t state_q, state_d;

	// The request being worked on and its classification.
	att_pkg::req_t    req_q;
	att_pkg::ev_kind_t kind_q;

	// Scan pointer and the read stage that holds its value from the cycle before.
	logic [IW-1:0] idx_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;

	// What the scan has found so far: the first live match of each address and
	// the first free slot.
	logic          hit_old_q, hit_new_q, free_found_q;
	logic [IW-1:0] old_idx_q, free_idx_q;
	logic [OB-1:0] old_owner_q;

	// Live counts and the sticky full flag.
	logic [CW-1:0] owner_cnt_q [att_pkg::OWNERS];
	logic [CW-1:0] total_q;
	logic          oom_q;

	logic          done_q;
	att_pkg::rsp_t result_q;

	// Memory port signals.
	logic          mem_we, mem_re;
	logic [IW-1:0] mem_waddr;
	logic [WB-1:0] mem_wdata, mem_rdata;

	logic          rd_valid;
	logic [OB-1:0] rd_owner;
	logic [AB-1:0] rd_addr;

	att_mem #(
		.DEPTH(TABLE_ENTRIES),
		.WIDTH(WB)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(idx_q),
		.rdata(mem_rdata)
	);

	assign rd_valid = mem_rdata[WB-1];
	assign rd_owner = mem_rdata[WB-2 -: OB];
	assign rd_addr  = mem_rdata[AB-1:0];

	// Request classification, used when the request is taken.
	att_pkg::ev_kind_t kind_in;
	logic              early_in;

	always_comb begin
		if (request.old_address == '0 && request.request_size != '0) begin
			kind_in  = att_pkg::EV_ALLOC;
			early_in = (request.new_address == '0) || oom_q;
		end else if (request.request_size == '0) begin
			kind_in  = att_pkg::EV_FREE;
			early_in = 1'b0;
		end else begin
			kind_in  = att_pkg::EV_REALLOC;
			early_in = (request.new_address == '0);
		end
	end

	logic accept;
	assign accept = start && (state_q == att_pkg::FSM_IDLE);

	// Verdict of a finished scan.
	att_pkg::status_t verdict;
	logic             same_owner;

	assign same_owner = (old_owner_q == req_q.owner_id);

	always_comb begin
		case (kind_q)
			att_pkg::EV_ALLOC: begin
				if (hit_new_q)
					verdict = att_pkg::ST_DUP;
				else if (!free_found_q)
					verdict = att_pkg::ST_OOM;
				else
					verdict = att_pkg::ST_ALLOC;
			end
			att_pkg::EV_FREE: begin
				if (!hit_old_q)
					verdict = att_pkg::ST_UNTRACKED;
				else if (!same_owner)
					verdict = att_pkg::ST_MISMATCH;
				else
					verdict = att_pkg::ST_FREED;
			end
			default: begin
				if (!hit_old_q)
					verdict = att_pkg::ST_UNTRACKED;
				else if (!same_owner)
					verdict = att_pkg::ST_MISMATCH;
				else if (hit_new_q && req_q.new_address != req_q.old_address)
					verdict = att_pkg::ST_DUP;
				else
					verdict = att_pkg::ST_REALLOC;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			att_pkg::FSM_CLEAR: begin
				if (idx_q == LAST_IDX)
					state_d = att_pkg::FSM_IDLE;
			end
			att_pkg::FSM_IDLE: begin
				if (accept) begin
					if (request.opcode == att_pkg::OP_BEGIN)
						state_d = att_pkg::FSM_CLEAR;
					else if (request.opcode == att_pkg::OP_EVENT && !early_in)
						state_d = att_pkg::FSM_SCAN;
				end
			end
			att_pkg::FSM_SCAN: begin
				if (idx_q == LAST_IDX)
					state_d = att_pkg::FSM_DRAIN;
			end
			att_pkg::FSM_DRAIN: begin
				state_d = att_pkg::FSM_DECIDE;
			end
			att_pkg::FSM_DECIDE: begin
				state_d = att_pkg::FSM_IDLE;
			end
			default: begin
				state_d = att_pkg::FSM_CLEAR;
			end
		endcase
	end

	// Outputs of the state machine: memory port and busy.
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		busy      = 1'b1;
		unique case (state_q)
			att_pkg::FSM_CLEAR: begin
				mem_we = 1'b1;
			end
			att_pkg::FSM_IDLE: begin
				busy = 1'b0;
			end
			att_pkg::FSM_SCAN: begin
				mem_re = 1'b1;
			end
			att_pkg::FSM_DRAIN: begin
				mem_re = 1'b0;
			end
			att_pkg::FSM_DECIDE: begin
				// A free writes the slot invalid; allocate and reallocate
				// write a full live entry.
				if (verdict == att_pkg::ST_ALLOC) begin
					mem_we    = 1'b1;
					mem_waddr = free_idx_q;
					mem_wdata = {1'b1, req_q.owner_id, req_q.request_size,
						req_q.new_address};
				end else if (verdict == att_pkg::ST_REALLOC) begin
					mem_we    = 1'b1;
					mem_waddr = old_idx_q;
					mem_wdata = {1'b1, req_q.owner_id, req_q.request_size,
						req_q.new_address};
				end else if (verdict == att_pkg::ST_FREED) begin
					mem_we    = 1'b1;
					mem_waddr = old_idx_q;
				end
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= att_pkg::FSM_CLEAR;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == att_pkg::FSM_CLEAR || state_q == att_pkg::FSM_SCAN) &&
				idx_q != LAST_IDX)
				idx_q <= idx_q + 1'b1;
			else
				idx_q <= '0;
		end
	end

	// Read stage: the data returning this cycle belongs to rd_idx_s1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= request;
			kind_q <= kind_in;
		end
	end

	// Scan findings. Only the first match is kept; addresses are unique among
	// live entries, so that is also the only one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_old_q    <= 1'b0;
			hit_new_q    <= 1'b0;
			free_found_q <= 1'b0;
		end else if (accept) begin
			hit_old_q    <= 1'b0;
			hit_new_q    <= 1'b0;
			free_found_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (rd_valid && rd_addr == req_q.old_address && !hit_old_q)
				hit_old_q <= 1'b1;
			if (rd_valid && rd_addr == req_q.new_address)
				hit_new_q <= 1'b1;
			if (!rd_valid && !free_found_q)
				free_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (rd_valid && rd_addr == req_q.old_address && !hit_old_q) begin
				old_idx_q   <= rd_idx_s1;
				old_owner_q <= rd_owner;
			end
			if (!rd_valid && !free_found_q)
				free_idx_q <= rd_idx_s1;
		end
	end

	// Counters, flag and the result register.
	logic [CW-1:0] total_next;

	always_comb begin
		total_next = total_q;
		if (verdict == att_pkg::ST_ALLOC)
			total_next = total_q + 1'b1;
		else if (verdict == att_pkg::ST_FREED)
			total_next = total_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < att_pkg::OWNERS; i++)
				owner_cnt_q[i] <= '0;
			total_q <= '0;
			oom_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				if (request.opcode == att_pkg::OP_BEGIN) begin
					for (int i = 0; i < att_pkg::OWNERS; i++)
						owner_cnt_q[i] <= '0;
					total_q <= '0;
					oom_q   <= 1'b0;
					done_q  <= 1'b1;
				end else if (request.opcode != att_pkg::OP_EVENT || early_in) begin
					done_q <= 1'b1;
				end
			end else if (state_q == att_pkg::FSM_DECIDE) begin
				done_q  <= 1'b1;
				total_q <= total_next;
				if (verdict == att_pkg::ST_ALLOC)
					owner_cnt_q[req_q.owner_id] <= owner_cnt_q[req_q.owner_id] + 1'b1;
				else if (verdict == att_pkg::ST_FREED)
					owner_cnt_q[req_q.owner_id] <= owner_cnt_q[req_q.owner_id] - 1'b1;
				if (verdict == att_pkg::ST_OOM)
					oom_q <= 1'b1;
			end
		end
	end

	// Result payload; the flag is the value after the request.
	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (request.opcode)
				att_pkg::OP_BEGIN: begin
					result_q.status        <= att_pkg::ST_CLEARED;
					result_q.live_count    <= '0;
					result_q.out_of_memory <= 1'b0;
				end
				att_pkg::OP_COUNT: begin
					result_q.status        <= att_pkg::ST_COUNT;
					result_q.live_count    <= request.query_all ?
						att_pkg::COUNT_BITS'(total_q) :
						att_pkg::COUNT_BITS'(owner_cnt_q[request.owner_id]);
					result_q.out_of_memory <= oom_q;
				end
				att_pkg::OP_EVENT: begin
					result_q.status        <= (request.new_address == '0) ?
						att_pkg::ST_FAILED : att_pkg::ST_OOM;
					result_q.live_count    <= att_pkg::COUNT_BITS'(total_q);
					result_q.out_of_memory <= oom_q;
				end
				default: begin
					result_q.status        <= att_pkg::ST_FAILED;
					result_q.live_count    <= att_pkg::COUNT_BITS'(total_q);
					result_q.out_of_memory <= oom_q;
				end
			endcase
		end else if (state_q == att_pkg::FSM_DECIDE) begin
			result_q.status        <= verdict;
			result_q.live_count    <= att_pkg::COUNT_BITS'(total_next);
			result_q.out_of_memory <= oom_q || (verdict == att_pkg::ST_OOM);
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// A result only follows a request answered at once or the end of a scan.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(accept || state_q == att_pkg::FSM_DECIDE))
		else $error("result without a request");

	// The live total never exceeds the table size.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(TABLE_ENTRIES))
		else $error("live total above table size");

	// A taken request either answers next cycle or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done_q || busy))
		else $error("request dropped");

	// The full flag is only raised by a finished allocate scan.
	a_oom_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(oom_q) |-> $past(state_q == att_pkg::FSM_DECIDE))
		else $error("full flag raised outside a scan verdict");
`endif

endmodule

// File: rtl/core/att_mem.sv
module att_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 85
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int AB = att_pkg::ADDRESS_BITS;
	localparam int SB = att_pkg::SIZE_BITS;
	localparam int OB = att_pkg::OWNER_BITS;
	localparam int NB = att_pkg::COUNT_BITS;

	// Opcode 3 has no name in the package; the block must treat it as a failed call.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SLOTS = 1024;
	localparam int STALL_LIMIT = 6000;

	typedef struct {
		logic [OB-1:0] owner;
		logic [SB-1:0] size;
	} alloc_rec_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic           busy;
	att_pkg::req_t  request = '0;
	logic           done;
	att_pkg::rsp_t  result;

	allocation_tracking_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the table: live allocations keyed by address, with per-owner counts
	// and the sticky out-of-memory flag.
	alloc_rec_t             live_allocs[logic [AB-1:0]];
	int unsigned            owner_counts[att_pkg::OWNERS];
	logic                   oom_flag = 1'b0;

	att_pkg::req_t          pending_requests[$];
	att_pkg::rsp_t          owed_results[$];
	int                     mismatches = 0;
	int                     stall_cycles = 0;
	int                     gap_left = 0;
	logic                   took = 1'b0;

	// Generator-side guess of what is live, used only to aim frees and reallocates
	// at addresses that are likely to hit.
	logic [AB-1:0] gen_addr[$];
	logic [OB-1:0] gen_owner[$];

	// Computes the answer to one request and advances the shadow table.
	function automatic att_pkg::rsp_t track_request(att_pkg::req_t r);
		att_pkg::rsp_t rsp;
		alloc_rec_t    rec;
		logic [AB-1:0] old_a;
		logic [AB-1:0] new_a;
		old_a = r.old_address;
		new_a = r.new_address;
		rsp.status = att_pkg::ST_FAILED;
		if (r.opcode == att_pkg::OP_EVENT) begin
			if (old_a == '0 && r.request_size != '0) begin
				if (new_a == '0)
					rsp.status = att_pkg::ST_FAILED;
				else if (oom_flag)
					rsp.status = att_pkg::ST_OOM;
				else if (live_allocs.exists(new_a))
					rsp.status = att_pkg::ST_DUP;
				else if (live_allocs.num() >= SLOTS) begin
					oom_flag = 1'b1;
					rsp.status = att_pkg::ST_OOM;
				end else begin
					rec.owner = r.owner_id;
					rec.size = r.request_size;
					live_allocs[new_a] = rec;
					owner_counts[r.owner_id]++;
					rsp.status = att_pkg::ST_ALLOC;
				end
			end else if (r.request_size == '0) begin
				// A null free lands here too and is simply untracked.
				if (!live_allocs.exists(old_a))
					rsp.status = att_pkg::ST_UNTRACKED;
				else if (live_allocs[old_a].owner != r.owner_id)
					rsp.status = att_pkg::ST_MISMATCH;
				else begin
					live_allocs.delete(old_a);
					owner_counts[r.owner_id]--;
					rsp.status = att_pkg::ST_FREED;
				end
			end else begin
				if (new_a == '0)
					rsp.status = att_pkg::ST_FAILED;
				else if (!live_allocs.exists(old_a))
					rsp.status = att_pkg::ST_UNTRACKED;
				else if (live_allocs[old_a].owner != r.owner_id)
					rsp.status = att_pkg::ST_MISMATCH;
				else if (new_a != old_a && live_allocs.exists(new_a))
					rsp.status = att_pkg::ST_DUP;
				else begin
					// Moving in place only changes the size.
					rec = live_allocs[old_a];
					rec.size = r.request_size;
					live_allocs.delete(old_a);
					live_allocs[new_a] = rec;
					rsp.status = att_pkg::ST_REALLOC;
				end
			end
			rsp.live_count = NB'(live_allocs.num());
		end else if (r.opcode == att_pkg::OP_COUNT) begin
			rsp.status = att_pkg::ST_COUNT;
			rsp.live_count = r.query_all ? NB'(live_allocs.num())
			                             : NB'(owner_counts[r.owner_id]);
		end else if (r.opcode == att_pkg::OP_BEGIN) begin
			live_allocs.delete();
			foreach (owner_counts[i])
				owner_counts[i] = 0;
			oom_flag = 1'b0;
			rsp.status = att_pkg::ST_CLEARED;
			rsp.live_count = '0;
		end else begin
			rsp.live_count = NB'(live_allocs.num());
		end
		rsp.out_of_memory = oom_flag;
		return rsp;
	endfunction

	// Mostly back-to-back requests, some short pauses and a few long ones.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	function automatic att_pkg::req_t make_req(logic [1:0] op, logic [OB-1:0] owner,
			logic all, logic [AB-1:0] old_a, logic [SB-1:0] size,
			logic [AB-1:0] new_a);
		att_pkg::req_t r;
		r.opcode = op;
		r.owner_id = owner;
		r.query_all = all;
		r.old_address = old_a;
		r.request_size = size;
		r.new_address = new_a;
		return r;
	endfunction

	function automatic logic [AB-1:0] rand_addr();
		// Half the addresses come from a small pool so that duplicates happen.
		if ($urandom_range(0, 1))
			return AB'({$urandom, $urandom});
		return AB'($urandom_range(1, 64));
	endfunction

	function automatic logic [SB-1:0] rand_size();
		return $urandom_range(0, 3) == 0 ? SB'($urandom_range(1, 16)) : $urandom | 1;
	endfunction

	// Requests are presented at the falling edge. A request is held until the
	// block takes it, then either the next one follows at once or start drops
	// for a random pause.
	always @(negedge clk) begin
		if (!arst_n)
			start <= 1'b0;
		else if (start && !took) begin
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pending_requests.size() > 0) begin
			start <= 1'b1;
			request <= pending_requests.pop_front();
			gap_left <= pick_gap();
		end else
			start <= 1'b0;
	end

	// Results are checked before the request taken at the same edge is predicted,
	// so an answer never meets its own expectation by accident.
	always @(posedge clk) begin
		att_pkg::rsp_t want;
		logic progress;
		took <= arst_n && start && !busy;
		progress = 1'b0;
		if (arst_n) begin
			if (done) begin
				progress = 1'b1;
				if (owed_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected: status %0d count %0d oom %0b",
						$realtime, result.status, result.live_count, result.out_of_memory);
				end else begin
					want = owed_results.pop_front();
					if (result.status != want.status) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d", $realtime,
							want.status, result.status);
					end
					if (result.live_count != want.live_count) begin
						mismatches++;
						$display("%0t: live_count expected %0d actual %0d", $realtime,
							want.live_count, result.live_count);
					end
					if (result.out_of_memory != want.out_of_memory) begin
						mismatches++;
						$display("%0t: out_of_memory expected %0b actual %0b", $realtime,
							want.out_of_memory, result.out_of_memory);
					end
				end
			end
			if (start && !busy) begin
				progress = 1'b1;
				owed_results.push_back(track_request(request));
			end
			// The limit leaves room for a clearing pass and a full scan back to back.
			stall_cycles = progress ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [AB-1:0] a_max;
		logic [AB-1:0] a_b;
		logic [AB-1:0] a_c;
		logic [AB-1:0] base;
		logic [AB-1:0] pick_a;
		logic [OB-1:0] pick_o;
		int            idx;
		int            roll;

		a_max = {AB{1'b1}};
		a_b = 48'h5555_AAAA_5555;
		a_c = 48'hAAAA_5555_AAAA;
		base = 48'h1000_0000_0000;

		// Directed: field extremes and every special case of an allocator event.
		pending_requests.push_back(make_req(att_pkg::OP_COUNT, 4'd0, 1'b1, '0, '0, '0));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd3, 1'b0, '0, '1, a_max));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd5, 1'b0, '0, 32'd8, a_max));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd3, 1'b0, '0, 32'd1, '0));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd3, 1'b0, '0, '0, '0));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd7, 1'b0, a_max, '0, '0));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd3, 1'b0, a_max, 32'd64,
			a_max));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd3, 1'b0, a_max, 32'd32, a_b));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd15, 1'b0, '0, 32'd16, a_c));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd3, 1'b0, a_b, 32'd16, a_c));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd15, 1'b0, a_b, 32'd16,
			a_max));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd3, 1'b0, a_b, 32'd16, '0));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd3, 1'b0, a_max, 32'd16, a_c));
		pending_requests.push_back(make_req(att_pkg::OP_COUNT, 4'd3, 1'b0, '0, '0, '0));
		pending_requests.push_back(make_req(att_pkg::OP_COUNT, 4'd15, 1'b0, '1, '1, '1));
		pending_requests.push_back(make_req(OP_UNUSED, 4'd0, 1'b1, a_max, '1, a_max));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd3, 1'b0, a_b, '0, '1));
		pending_requests.push_back(make_req(att_pkg::OP_COUNT, 4'd3, 1'b1, '0, '0, '0));
		pending_requests.push_back(make_req(att_pkg::OP_BEGIN, 4'd9, 1'b1, '1, '1, '1));
		pending_requests.push_back(make_req(att_pkg::OP_COUNT, 4'd15, 1'b0, '0, '0, '0));

		// Fill the table to one past its capacity to raise the sticky flag, then
		// show that a free does not clear it and that begin does.
		for (int i = 0; i <= SLOTS; i++)
			pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'(i), 1'b0, '0,
				rand_size(), base + AB'(i * 16)));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd2, 1'b0, '0, 32'd4,
			48'h123));
		pending_requests.push_back(make_req(att_pkg::OP_COUNT, 4'd4, 1'b0, '0, '0, '0));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd0, 1'b0, base, '0, '0));
		pending_requests.push_back(make_req(att_pkg::OP_EVENT, 4'd1, 1'b0, '0, 32'd4,
			48'h456));
		pending_requests.push_back(make_req(att_pkg::OP_COUNT, 4'd0, 1'b1, '0, '0, '0));
		pending_requests.push_back(make_req(att_pkg::OP_BEGIN, 4'd0, 1'b0, '0, '0, '0));

		// Random part: mostly well-formed allocate, free and reallocate traffic
		// aimed at addresses that are probably live, with queries, an occasional
		// begin and some fully random noise.
		for (int n = 0; n < 380; n++) begin
			roll = $urandom_range(0, 99);
			idx = gen_addr.size() > 0 ? $urandom_range(0, gen_addr.size() - 1) : -1;
			pick_a = idx >= 0 ? gen_addr[idx] : rand_addr();
			pick_o = idx >= 0 ? gen_owner[idx] : 4'($urandom);
			if (roll < 30 || idx < 0) begin
				pick_a = rand_addr();
				pick_o = 4'($urandom);
				pending_requests.push_back(make_req(att_pkg::OP_EVENT, pick_o, 1'($urandom),
					'0, rand_size() | 1, pick_a));
				gen_addr.push_back(pick_a);
				gen_owner.push_back(pick_o);
			end else if (roll < 50) begin
				// Now and then the wrong owner tries to free it.
				if ($urandom_range(0, 7) == 0)
					pick_o = pick_o + 4'd1;
				pending_requests.push_back(make_req(att_pkg::OP_EVENT, pick_o, 1'($urandom),
					pick_a, '0, $urandom_range(0, 1) ? '0 : rand_addr()));
				gen_addr.delete(idx);
				gen_owner.delete(idx);
			end else if (roll < 66) begin
				gen_addr[idx] = $urandom_range(0, 5) == 0 ? pick_a : rand_addr();
				pending_requests.push_back(make_req(att_pkg::OP_EVENT, pick_o, 1'($urandom),
					pick_a, rand_size() | 1, gen_addr[idx]));
			end else if (roll < 76) begin
				pending_requests.push_back(make_req(att_pkg::OP_COUNT, 4'($urandom),
					1'($urandom), rand_addr(), $urandom, rand_addr()));
			end else if (roll < 78) begin
				pending_requests.push_back(make_req(att_pkg::OP_BEGIN, 4'($urandom),
					1'($urandom), rand_addr(), $urandom, rand_addr()));
				gen_addr.delete();
				gen_owner.delete();
			end else begin
				pending_requests.push_back(make_req(2'($urandom), 4'($urandom),
					1'($urandom), $urandom_range(0, 1) ? pick_a : rand_addr(),
					$urandom_range(0, 2) == 0 ? '0 : $urandom,
					$urandom_range(0, 3) == 0 ? '0 : rand_addr()));
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(posedge clk);
		while (pending_requests.size() != 0 || start || owed_results.size() != 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: allocation_tracking_table.f
rtl/core/att_pkg.sv
rtl/core/att_mem.sv
rtl/core/allocation_tracking_table.sv
tb/sv/tb_top.sv
